// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by the scheduler top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/rbps_pkg.sv -----
`timescale 1ns / 1ps

package rbps_pkg;

    // priorities per bitmap row
    localparam int ROW_BITS = 16;
    localparam logic [ROW_BITS-1:0] LOW_BIT = 16'h0001;

    // configuration register indexes
    localparam logic REG_RUNNING = 1'b0;

    // scheduler commands
    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_RESUME = 3'd1,
        CMD_HOLD   = 3'd2,
        CMD_EXIT   = 3'd3,
        CMD_DELETE = 3'd4,
        CMD_CHECK  = 3'd5
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_TAKEN = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // index of the lowest set bit, top index when none is set
    function automatic logic [3:0] lowest_bit(input logic [ROW_BITS-1:0] v);
        logic [3:0] idx;
        idx = 4'(ROW_BITS - 1);
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- hw/rtl/ready_bitmap_priority_scheduler_top.sv -----
`timescale 1ns / 1ps
// channel   valid      stall      payload
// in        in_valid   in_stall   command, prio, start_ready, use_current, current_prio
// out       out_valid  out_stall  status, switch_request, top_prio, any_ready
// cfg       apb write  -          scheduler_running at byte address 0
//
// one transaction per cycle sustained while the output is not stalled; a command is
// registered in the input register, the slot store and ready bitmaps update and the
// two find-first-set steps run while it is held there, and the result lands in the output register.
// reset clears the slot store, the bitmaps and the running flag at once.
// a stalled output holds the input register, which then stalls the input side.

`include "assert_macros.svh"

module ready_bitmap_priority_scheduler_top #(
    parameter int ROW_COUNT  = 16,
    parameter int SLOT_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  prio,
    input  logic        start_ready,
    input  logic        use_current,
    input  logic [7:0]  current_prio,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        switch_request,
    output logic [7:0]  top_prio,
    output logic        any_ready,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import rbps_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // configuration
    logic running_reg;
    logic cfg_write;

    // input register
    logic       s1_valid_reg;
    logic [2:0] cmd_reg;
    logic [7:0] prio_reg;
    logic       start_reg;
    logic       use_cur_reg;
    logic [7:0] cur_reg;

    // scheduler state
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [ROW_BITS-1:0]   ready_rows_reg [ROW_COUNT];
    logic [ROW_BITS-1:0]   ready_rows_next [ROW_COUNT];
    logic [ROW_COUNT-1:0]  ready_group_reg;
    logic [ROW_COUNT-1:0]  ready_group_next;
    logic [ROW_COUNT-1:0]  row_nz_reg;

    // output register
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic       sw_reg;
    logic [7:0] top_reg;
    logic       any_reg;

    // command decode
    logic       advance;
    logic [7:0] target;
    logic [7:0] sel_prio;
    logic       in_range;
    logic       slot_live;
    logic [ROW_BITS-1:0] bit_mask;
    status_t    st;
    logic       sw_cmd;
    logic       set_ready;
    logic       clr_ready;
    logic       set_valid;
    logic       clr_valid;

    // search
    logic [ROW_BITS-1:0] grp16;
    logic [3:0]          grp_idx;
    logic [ROW_BITS-1:0] row_nz_ext;
    logic [3:0]          row_low_ext [ROW_BITS];
    logic                any_next;
    logic [7:0]          top_next;
    logic                sw_next;

    // handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;

    assign status         = status_reg;
    assign switch_request = sw_reg;
    assign top_prio       = top_reg;
    assign any_ready      = any_reg;

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_RUNNING);
    assign prdata    = (paddr[2] == REG_RUNNING) ? 32'(running_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            running_reg <= pwdata[0];
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg     <= command;
            prio_reg    <= prio;
            start_reg   <= start_ready;
            use_cur_reg <= use_current;
            cur_reg     <= current_prio;
        end
    end

    // slot addressed by the command
    assign target = use_cur_reg ? cur_reg : prio_reg;

    always_comb
    begin
        case (cmd_t'(cmd_reg))
            CMD_HOLD:   sel_prio = target;
            CMD_DELETE: sel_prio = target;
            CMD_EXIT:   sel_prio = cur_reg;
            default:    sel_prio = prio_reg;
        endcase
    end

    assign in_range  = ({1'b0, sel_prio} < 9'(SLOT_COUNT)) &&
                       ({1'b0, sel_prio[7:4]} < 5'(ROW_COUNT));
    assign slot_live = in_range && slot_valid_reg[sel_prio[SLOT_W-1:0]];
    assign bit_mask  = LOW_BIT << sel_prio[3:0];

    // command effects
    always_comb
    begin
        st        = ST_DONE;
        sw_cmd    = 1'b0;
        set_ready = 1'b0;
        clr_ready = 1'b0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        case (cmd_t'(cmd_reg))
            CMD_CREATE:
            begin
                if (!in_range || slot_live)
                begin
                    st = ST_TAKEN;
                end
                else
                begin
                    set_valid = 1'b1;
                    set_ready = start_reg;
                    sw_cmd    = start_reg && (cur_reg > prio_reg);
                end
            end
            CMD_RESUME:
            begin
                if (!slot_live)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    set_ready = 1'b1;
                    sw_cmd    = prio_reg < cur_reg;
                end
            end
            CMD_HOLD:
            begin
                if (!slot_live)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    clr_ready = 1'b1;
                    sw_cmd    = target == cur_reg;
                end
            end
            CMD_EXIT:
            begin
                if (!slot_live)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    clr_ready = 1'b1;
                    sw_cmd    = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (!slot_live)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    clr_valid = 1'b1;
                    clr_ready = 1'b1;
                    sw_cmd    = target == cur_reg;
                end
            end
            default:
            begin
                st = ST_DONE;
            end
        endcase
    end

    // slot store update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (advance && set_valid)
        begin
            slot_valid_reg[sel_prio[SLOT_W-1:0]] <= 1'b1;
        end
        else if (advance && clr_valid)
        begin
            slot_valid_reg[sel_prio[SLOT_W-1:0]] <= 1'b0;
        end
    end

    // per-row bitmap update and lowest-bit search
    for (genvar r = 0; r < ROW_BITS; r++)
    begin : g_row
        if (r < ROW_COUNT)
        begin : g_used
            logic hit;
            assign hit = sel_prio[7:4] == 4'(r);

            always_comb
            begin
                ready_rows_next[r]  = ready_rows_reg[r];
                ready_group_next[r] = ready_group_reg[r];
                if (hit && set_ready)
                begin
                    ready_rows_next[r]  = ready_rows_reg[r] | bit_mask;
                    ready_group_next[r] = 1'b1;
                end
                else if (hit && clr_ready)
                begin
                    ready_rows_next[r] = ready_rows_reg[r] & ~bit_mask;
                    if (ready_rows_next[r] == '0)
                    begin
                        ready_group_next[r] = 1'b0;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ready_rows_reg[r]  <= '0;
                    ready_group_reg[r] <= 1'b0;
                end
                else if (advance)
                begin
                    ready_rows_reg[r]  <= ready_rows_next[r];
                    ready_group_reg[r] <= ready_group_next[r];
                end
            end

            assign row_nz_reg[r]  = |ready_rows_reg[r];
            assign row_nz_ext[r]  = |ready_rows_next[r];
            assign row_low_ext[r] = lowest_bit(ready_rows_next[r]);
        end
        else
        begin : g_unused
            assign row_nz_ext[r]  = 1'b0;
            assign row_low_ext[r] = 4'd0;
        end
    end

    // group search after the update
    assign grp16    = 16'(ready_group_next);
    assign grp_idx  = lowest_bit(grp16);
    assign any_next = (grp16 != '0) && row_nz_ext[grp_idx];
    assign top_next = any_next ? {grp_idx, row_low_ext[grp_idx]} : 8'd0;

    // switch decision
    always_comb
    begin
        sw_next = sw_cmd;
        if (cmd_t'(cmd_reg) == CMD_CHECK)
        begin
            sw_next = any_next && (top_next != cur_reg);
        end
        if (!running_reg)
        begin
            sw_next = 1'b0;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= st;
            sw_reg     <= sw_next;
            top_reg    <= top_next;
            any_reg    <= any_next;
        end
    end

    // group bits track nonzero rows
    `ASSERT_ALWAYS(a_group_match, clk, rst_n, ready_group_reg == row_nz_reg)
    // empty ready list reports priority zero
    `ASSERT_IMPLY(a_empty_top, clk, rst_n, out_valid_reg && !any_reg, top_reg == 8'd0)
    // input side stalls only behind a held result
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall)

endmodule

// ----- tb/sched_checker.sv -----
`timescale 1ns / 1ps

module sched_checker #(
    parameter int ROW_COUNT  = 16,
    parameter int SLOT_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  prio,
    input  logic        start_ready,
    input  logic        use_current,
    input  logic [7:0]  current_prio,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic        switch_request,
    input  logic [7:0]  top_prio,
    input  logic        any_ready,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          fail_count,
    output int          pending
);

    import rbps_pkg::*;

    localparam logic [2:0] ADDR_RUNNING = {REG_RUNNING, 2'b00};
    localparam logic [ROW_BITS-1:0] GROUP_MASK = ROW_BITS'((32'h1 << ROW_COUNT) - 1);

    typedef struct packed {
        status_t    status;
        logic       switch_req;
        logic [7:0] top;
        logic       any;
    } sched_result_t;

    // scheduler state as seen by the predictor
    logic                running;
    logic                slot_valid  [SLOT_COUNT];
    logic                slot_held   [SLOT_COUNT];
    logic                slot_exited [SLOT_COUNT];
    logic [ROW_BITS-1:0] ready_group;
    logic [ROW_BITS-1:0] ready_rows  [ROW_COUNT];

    sched_result_t expected_q[$];
    sched_result_t want;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic slot_exists(logic [7:0] p);
        return (int'(p) < SLOT_COUNT) && (int'(p) / ROW_BITS < ROW_COUNT);
    endfunction

    function automatic logic slot_occupied(logic [7:0] p);
        if (!slot_exists(p))
        begin
            return 1'b0;
        end
        return slot_valid[p];
    endfunction

    function automatic void set_ready(logic [7:0] p);
        int row;
        row = int'(p) / ROW_BITS;
        ready_rows[row] = ready_rows[row] | (LOW_BIT << (int'(p) % ROW_BITS));
        ready_group = ready_group | (LOW_BIT << row);
    endfunction

    function automatic void clear_ready(logic [7:0] p);
        int row;
        row = int'(p) / ROW_BITS;
        ready_rows[row] = ready_rows[row] & ~(LOW_BIT << (int'(p) % ROW_BITS));
        if (ready_rows[row] == '0)
        begin
            ready_group = ready_group & ~(LOW_BIT << row);
        end
    endfunction

    // lowest set bit, top index when the vector is empty
    function automatic int first_set(logic [ROW_BITS-1:0] v);
        int idx;
        logic found;
        idx = ROW_BITS - 1;
        found = 1'b0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (v[i] && !found)
            begin
                idx = i;
                found = 1'b1;
            end
        end
        return idx;
    endfunction

    // apply one command to the ready list and work out its result
    function automatic sched_result_t schedule_step(logic [2:0] cmd, logic [7:0] p,
                                                    logic sr, logic uc, logic [7:0] cur);
        sched_result_t res;
        logic [7:0] tgt;
        logic [ROW_BITS-1:0] grp;
        logic [ROW_BITS-1:0] bits;
        int row;
        tgt = uc ? cur : p;
        res.status = ST_DONE;
        res.switch_req = 1'b0;
        res.top = 8'd0;
        res.any = 1'b0;
        case (cmd)
            CMD_CREATE:
            begin
                if (!slot_exists(p) || slot_valid[p])
                begin
                    res.status = ST_TAKEN;
                end
                else
                begin
                    slot_valid[p] = 1'b1;
                    slot_exited[p] = 1'b0;
                    slot_held[p] = !sr;
                    if (sr)
                    begin
                        set_ready(p);
                        res.switch_req = cur > p;
                    end
                end
            end
            CMD_RESUME:
            begin
                if (!slot_occupied(p))
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    slot_held[p] = 1'b0;
                    slot_exited[p] = 1'b0;
                    set_ready(p);
                    res.switch_req = p < cur;
                end
            end
            CMD_HOLD:
            begin
                if (!slot_occupied(tgt))
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    slot_held[tgt] = 1'b1;
                    clear_ready(tgt);
                    res.switch_req = tgt == cur;
                end
            end
            CMD_EXIT:
            begin
                if (!slot_occupied(cur))
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    clear_ready(cur);
                    slot_held[cur] = 1'b1;
                    slot_exited[cur] = 1'b1;
                    res.switch_req = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (!slot_occupied(tgt))
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    slot_valid[tgt] = 1'b0;
                    slot_held[tgt] = 1'b0;
                    slot_exited[tgt] = 1'b0;
                    clear_ready(tgt);
                    res.switch_req = tgt == cur;
                end
            end
            default:
            begin
            end
        endcase

        // two-level search for the most urgent ready priority
        grp = ready_group & GROUP_MASK;
        if (grp != '0)
        begin
            row = first_set(grp);
            bits = ready_rows[row % ROW_COUNT];
            if (bits != '0)
            begin
                res.any = 1'b1;
                res.top = 8'(row * ROW_BITS + first_set(bits));
            end
        end
        if (cmd == CMD_CHECK)
        begin
            res.switch_req = res.any && (res.top != cur);
        end
        if (!running)
        begin
            res.switch_req = 1'b0;
        end
        return res;
    endfunction

    task automatic check_field(string field, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    // watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_held[i] = 1'b0;
                slot_exited[i] = 1'b0;
            end
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                ready_rows[r] = '0;
            end
            ready_group = '0;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RUNNING)
            begin
                running = pwdata[0];
            end

            // result transaction: compare with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d switch %0d top %0d any %0d",
                             $time, status, switch_request, top_prio, any_ready);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", 8'(want.status), 8'(status));
                    check_field("switch_request", 8'(want.switch_req), 8'(switch_request));
                    check_field("top_prio", want.top, top_prio);
                    check_field("any_ready", 8'(want.any), 8'(any_ready));
                end
            end

            // command transaction: predict its result
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(schedule_step(command, prio, start_ready,
                                                   use_current, current_prio));
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rbps_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [2:0] ADDR_RUNNING = {REG_RUNNING, 2'b00};
    localparam logic [2:0] ADDR_SPARE   = 3'd4;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT   = 5;
    localparam int PHASE_ITEMS   = 240;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [7:0]  prio;
    logic        start_ready;
    logic        use_current;
    logic [7:0]  current_prio;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        switch_request;
    logic [7:0]  top_prio;
    logic        any_ready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    bit          quiet;
    logic [7:0]  window_base;

    ready_bitmap_priority_scheduler_top u_top (.*);

    sched_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        out_stall = !quiet && ($urandom_range(0, 99) < 20);
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // one command transaction, with an optional idle gap ahead of it
    task automatic issue(logic [2:0] cmd, logic [7:0] p, logic sr, logic uc,
                         logic [7:0] cur);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 2);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command = cmd;
        prio = p;
        start_ready = sr;
        use_current = uc;
        current_prio = cur;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // mostly a narrow window so slots collide, sometimes anywhere
    function automatic logic [7:0] pick_prio();
        if ($urandom_range(0, 99) < 70)
        begin
            return window_base + 8'($urandom_range(0, 23));
        end
        return 8'($urandom);
    endfunction

    task automatic random_command();
        int r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            cmd = CMD_CREATE;
        end
        else if (r < 37)
        begin
            cmd = CMD_RESUME;
        end
        else if (r < 52)
        begin
            cmd = CMD_HOLD;
        end
        else if (r < 62)
        begin
            cmd = CMD_EXIT;
        end
        else if (r < 77)
        begin
            cmd = CMD_DELETE;
        end
        else if (r < 97)
        begin
            cmd = CMD_CHECK;
        end
        else
        begin
            cmd = r[0] ? CMD_SPARE_LO : CMD_SPARE_HI;
        end
        issue(cmd, pick_prio(), 1'($urandom), 1'($urandom), pick_prio());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_CHECK;
        prio = 8'd0;
        start_ready = 1'b0;
        use_current = 1'b0;
        current_prio = 8'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        quiet = 1'b0;
        window_base = 8'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // scheduler stopped: no switch requests at all
        issue(CMD_CHECK, 8'd0, 1'b0, 1'b0, 8'd0);
        issue(CMD_CREATE, 8'd0, 1'b1, 1'b0, 8'd255);
        issue(CMD_CREATE, 8'd0, 1'b1, 1'b0, 8'd255);
        issue(CMD_CREATE, 8'd255, 1'b0, 1'b0, 8'd0);
        issue(CMD_RESUME, 8'd255, 1'b0, 1'b0, 8'd0);
        issue(CMD_HOLD, 8'd0, 1'b0, 1'b0, 8'd0);
        issue(CMD_RESUME, 8'd17, 1'b0, 1'b0, 8'd0);
        issue(CMD_CHECK, 8'h55, 1'b1, 1'b1, 8'hAA);
        drain();
        apb_write(ADDR_RUNNING, 32'd1);

        // scheduler running: every command and the empty-slot answers
        issue(CMD_CREATE, 8'd16, 1'b1, 1'b0, 8'd255);
        issue(CMD_CREATE, 8'd240, 1'b1, 1'b0, 8'd0);
        issue(CMD_CHECK, 8'd0, 1'b0, 1'b0, 8'd0);
        issue(CMD_CHECK, 8'd0, 1'b0, 1'b0, 8'd16);
        issue(CMD_HOLD, 8'h55, 1'b0, 1'b1, 8'd16);
        issue(CMD_EXIT, 8'd0, 1'b0, 1'b0, 8'd240);
        issue(CMD_EXIT, 8'd0, 1'b0, 1'b0, 8'd128);
        issue(CMD_DELETE, 8'd255, 1'b0, 1'b0, 8'd0);
        issue(CMD_DELETE, 8'hAA, 1'b0, 1'b1, 8'd0);
        issue(CMD_DELETE, 8'd200, 1'b0, 1'b0, 8'd0);
        issue(CMD_HOLD, 8'd3, 1'b0, 1'b0, 8'd3);
        issue(CMD_SPARE_LO, 8'd16, 1'b1, 1'b1, 8'd255);
        issue(CMD_SPARE_HI, 8'd16, 1'b0, 1'b0, 8'd255);
        issue(CMD_RESUME, 8'd16, 1'b0, 1'b0, 8'd200);
        issue(CMD_CHECK, 8'd0, 1'b0, 1'b0, 8'd255);

        // random phases, each after its own register writes
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain();
            case (ph)
                0: apb_write(ADDR_SPARE, 32'd0);
                1: apb_write(ADDR_RUNNING, 32'hFFFF_FFFE);
                2: apb_write(ADDR_RUNNING, 32'hFFFF_FFFF);
                3: apb_write(ADDR_RUNNING, 32'd0);
                default:
                begin
                    apb_write(ADDR_RUNNING, 32'd1);
                    apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
                end
            endcase
            quiet = (ph == 2);
            if (ph == 0)
            begin
                window_base = 8'd0;
            end
            else if (ph == PHASE_COUNT - 1)
            begin
                window_base = 8'hF0;
            end
            else
            begin
                window_base = 8'($urandom);
            end
            repeat (PHASE_ITEMS) random_command();
        end
        quiet = 1'b0;

        drain();
        if (fail_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rbps_pkg.sv
hw/rtl/ready_bitmap_priority_scheduler_top.sv
tb/sched_checker.sv
tb/tb_top.sv
